// ===== src/utf8rv_pkg.sv =====
`timescale 1ns / 1ps

package utf8rv_pkg;

  // lead bytes that narrow the range of the byte after them
  localparam logic [7:0] LEAD_E0 = 8'hE0;
  localparam logic [7:0] LEAD_ED = 8'hED;
  localparam logic [7:0] LEAD_F0 = 8'hF0;
  localparam logic [7:0] LEAD_F4 = 8'hF4;

  // class thresholds
  localparam logic [7:0] LEAD2_MIN = 8'hC0;
  localparam logic [7:0] LEAD3_MIN = 8'hE0;
  localparam logic [7:0] LEAD4_MIN = 8'hF0;

  localparam int IDX_W = 4;
  localparam int RANGES = 16;

  typedef logic [7:0] byte_t;
  typedef logic [IDX_W-1:0] range_idx_t;

  // min and max byte per range index; indices 9..15 accept nothing
  localparam byte_t RANGE_LO [RANGES] = '{
    8'h00, 8'h80, 8'h80, 8'h80, 8'hA0, 8'h80, 8'h90, 8'h80, 8'hC2,
    8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF
  };
  localparam byte_t RANGE_HI [RANGES] = '{
    8'h7F, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'h9F, 8'hBF, 8'h8F, 8'hF4,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  // continuation bytes still owed after this byte
  function automatic logic [1:0] owed(input byte_t b);
    logic [1:0] n;
    if (b >= LEAD4_MIN) begin
      n = 2'd3;
    end else if (b >= LEAD3_MIN) begin
      n = 2'd2;
    end else if (b >= LEAD2_MIN) begin
      n = 2'd1;
    end else begin
      n = 2'd0;
    end
    return n;
  endfunction

endpackage

// ===== src/utf8rv_in_if.sv =====
`timescale 1ns / 1ps

interface utf8rv_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] bytes_low;
  logic [63:0] bytes_high;
  logic [4:0]  byte_count;
  logic        end_of_stream;

  modport source (output valid, bytes_low, bytes_high, byte_count, end_of_stream,
                  input ready);
  modport sink (input valid, bytes_low, bytes_high, byte_count, end_of_stream,
                output ready);
endinterface

// ===== src/utf8rv_out_if.sv =====
`timescale 1ns / 1ps

interface utf8rv_out_if;
  logic valid;
  logic ready;
  logic error_seen;
  logic stream_done;
  logic stream_valid;

  modport source (output valid, error_seen, stream_done, stream_valid, input ready);
  modport sink (input valid, error_seen, stream_done, stream_valid, output ready);
endinterface

// ===== src/utf8rv_lane.sv =====
`timescale 1ns / 1ps

module utf8rv_lane
  import utf8rv_pkg::*;
(
  input  byte_t cur,
  input  byte_t prev1,
  input  byte_t prev2,
  input  byte_t prev3,
  output logic  bad
);

  logic [1:0] own1;
  logic [1:0] own2;
  logic [1:0] own3;
  range_idx_t base_idx;
  range_idx_t adj;
  range_idx_t idx;

  always_comb begin
    own1 = owed(prev1);
    own2 = owed(prev2);
    own3 = owed(prev3);
    base_idx = {(cur >= LEAD2_MIN), 3'b000}
             | {2'b00, own1}
             | {2'b00, (own2 > 2'd1) ? own2 - 2'd1 : 2'd0}
             | {2'b00, (own3 > 2'd2) ? own3 - 2'd2 : 2'd0};
    priority if (prev1 == LEAD_E0) begin
      adj = 4'd2;
    end else if (prev1 == LEAD_ED) begin
      adj = 4'd3;
    end else if (prev1 == LEAD_F0) begin
      adj = 4'd3;
    end else if (prev1 == LEAD_F4) begin
      adj = 4'd4;
    end else begin
      adj = 4'd0;
    end
    // wraps mod 16 like the index mask
    idx = base_idx + adj;
    bad = (cur < RANGE_LO[idx]) || (cur > RANGE_HI[idx]);
  end

endmodule

// ===== src/utf8_range_validator.sv =====
`timescale 1ns / 1ps

// channel  | dir | beat fields
// ---------+-----+-------------------------------------------------------
// stream   | in  | bytes_low, bytes_high, byte_count, end_of_stream
// verdict  | out | error_seen, stream_done, stream_valid
//
// one beat per cycle sustained while verdict.ready holds; an accepted beat
// goes to the input register, then per-lane range check into result reg
// all LANES bytes are checked in parallel, so byte_count does not change rate
// rst clears history, sticky error and both valid flags; no clearing pass
// a stalled verdict holds the input register, and stream.ready drops only
// when both the input register and the result register are full

module utf8_range_validator
  import utf8rv_pkg::*;
#(
  parameter int LANES = 16
) (
  input  logic         clk,
  input  logic         rst,
  utf8rv_in_if.sink    stream,
  utf8rv_out_if.source verdict
);

  localparam int CNT_W = $clog2(LANES + 1);
  localparam int DATA_W = LANES * 8;
  localparam logic [4:0] LANES_CNT = 5'(LANES);

  // input register
  logic              s1_valid;
  logic [DATA_W-1:0] s1_data;
  logic [CNT_W-1:0]  s1_cnt;
  logic              s1_eos;

  // stream state
  logic [23:0] history;
  logic        sticky;

  // result register
  logic out_valid;
  logic out_error;
  logic out_done;
  logic out_ok;

  logic advance;
  logic take_in;

  logic [127:0]     in_data;
  logic [CNT_W-1:0] in_cnt;

  // per-lane check over a window of three history bytes plus this beat
  byte_t       win [LANES+3];
  logic [LANES-1:0] lane_bad;
  logic [LANES-1:0] lane_live;
  logic        any_bad;
  logic [23:0] history_next;
  logic        sticky_next;
  logic        trunc;

  // the result register frees up when it is empty or being drained
  assign advance = s1_valid && (!out_valid || verdict.ready);
  assign stream.ready = !s1_valid || advance;
  assign take_in = stream.valid && stream.ready;

  assign in_data = {stream.bytes_high, stream.bytes_low};
  // counts above LANES saturate
  assign in_cnt = (stream.byte_count > LANES_CNT) ? CNT_W'(LANES)
                                                  : CNT_W'(stream.byte_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (take_in) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_in) begin
      s1_data <= in_data[DATA_W-1:0];
      s1_cnt  <= in_cnt;
      s1_eos  <= stream.end_of_stream;
    end
  end

  always_comb begin
    win[0] = history[23:16];
    win[1] = history[15:8];
    win[2] = history[7:0];
    for (int i = 0; i < LANES; i++) begin
      win[i+3] = s1_data[8*i +: 8];
    end
  end

  genvar g;
  generate
    for (g = 0; g < LANES; g++) begin : g_lane
      utf8rv_lane u_lane (
        .cur   (win[g+3]),
        .prev1 (win[g+2]),
        .prev2 (win[g+1]),
        .prev3 (win[g]),
        .bad   (lane_bad[g])
      );
      // bytes past byte_count are ignored
      assign lane_live[g] = CNT_W'(g) < s1_cnt;
    end
  endgenerate

  assign any_bad = |(lane_bad & lane_live);

  // the last three bytes consumed become the new history
  always_comb begin
    history_next = history;
    for (int k = 0; k <= LANES; k++) begin
      if (s1_cnt == CNT_W'(k)) begin
        history_next = {win[k], win[k+1], win[k+2]};
      end
    end
  end

  assign sticky_next = sticky || any_bad;

  // a lead byte near the end that still waits for continuation bytes
  assign trunc = (owed(history_next[7:0]) >= 2'd1)
              || (owed(history_next[15:8]) >= 2'd2)
              || (owed(history_next[23:16]) >= 2'd3);

  always_ff @(posedge clk) begin
    if (rst) begin
      history <= '0;
      sticky  <= 1'b0;
    end else if (advance) begin
      if (s1_eos) begin
        // closing beat starts the next stream clean
        history <= '0;
        sticky  <= 1'b0;
      end else begin
        history <= history_next;
        sticky  <= sticky_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (verdict.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_error <= sticky_next;
      out_done  <= s1_eos;
      out_ok    <= s1_eos && !sticky_next && !trunc;
    end
  end

  assign verdict.valid        = out_valid;
  assign verdict.error_seen   = out_error;
  assign verdict.stream_done  = out_done;
  assign verdict.stream_valid = out_ok;

  // a closing beat leaves no history or error behind
  a_close_clears : assert property (@(posedge clk) disable iff (rst)
    $past(advance && s1_eos && !rst) |-> (history == '0) && !sticky)
    else $error("state not cleared after end of stream");

  // error stays set inside a stream
  a_sticky_holds : assert property (@(posedge clk) disable iff (rst)
    ($past(sticky && !rst) && !$past(advance && s1_eos)) |-> sticky)
    else $error("sticky error dropped mid-stream");

  // a valid verdict is only given on a clean closing beat
  a_ok_consistent : assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ok) |-> (out_done && !out_error))
    else $error("stream_valid without done or with error");

  // every beat that leaves the input register lands in the result register
  a_advance_lands : assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("result lost on advance");

endmodule
